// ----- src/lsoc_pkg.sv -----
package lsoc_pkg;

	localparam int unsigned DATA_W = 64;
	localparam int unsigned TYPE_W = 32;
	localparam int unsigned HIT_W  = 4;
	localparam int unsigned STAT_W = 3;
	localparam int unsigned CNT_OUT_W = 5;

	localparam logic [TYPE_W-1:0] SEG_TYPE_LOAD = 32'd1;

	typedef enum logic [STAT_W-1:0] {
		ST_OK         = 3'd0,
		ST_BEYOND     = 3'd1,
		ST_MISALIGNED = 3'd2,
		ST_OVERLAP    = 3'd3,
		ST_FULL       = 3'd4,
		ST_SKIPPED    = 3'd5
	} status_t;

	// candidate range walking down the cell row
	typedef struct packed {
		logic              valid;
		logic [DATA_W-1:0] range_lo;
		logic [DATA_W-1:0] range_hi;
		logic              hit;
		logic [HIT_W-1:0]  hit_idx;
	} probe_t;

endpackage

// ----- src/lsoc_cell.sv -----
module lsoc_cell
	import lsoc_pkg::*;
#(
	parameter int unsigned INDEX = 0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  probe_t            probe_in,
	output probe_t            probe_out,
	input  logic              live,
	input  logic              wr_en,
	input  logic [DATA_W-1:0] wr_lo,
	input  logic [DATA_W-1:0] wr_hi
);

	logic [DATA_W-1:0] lo_q;
	logic [DATA_W-1:0] hi_q;
	logic              overlap;
	logic              valid_q;
	logic [DATA_W-1:0] range_lo_q;
	logic [DATA_W-1:0] range_hi_q;
	logic              hit_q;
	logic [HIT_W-1:0]  hit_idx_q;

	// inclusive ranges overlap when each begin is at most the other's end
	assign overlap = live && (probe_in.range_lo <= hi_q) && (lo_q <= probe_in.range_hi);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			lo_q <= wr_lo;
			hi_q <= wr_hi;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= probe_in.valid;
		end
	end

	// lowest index wins: an earlier hit passes through untouched
	always_ff @(posedge clk) begin
		range_lo_q <= probe_in.range_lo;
		range_hi_q <= probe_in.range_hi;
		hit_q      <= probe_in.hit | overlap;
		hit_idx_q  <= probe_in.hit ? probe_in.hit_idx : HIT_W'(INDEX);
	end

	assign probe_out = {valid_q, range_lo_q, range_hi_q, hit_q, hit_idx_q};

endmodule

// ----- src/load_segment_overlap_checker_core.sv -----
// channel | dir | signals                       | item
// s       | in  | s_tvalid s_tready s_tdata s_tuser | one segment descriptor
// m       | out | m_tvalid m_tready m_tdata     | one check result
// cfg     | in  | cfg_we cfg_wdata              | buffer_length register
//
// one item at a time: a non-loadable, skipped, out-of-bounds or misaligned item goes
// from S_CHECK straight to S_DONE, a loadable item that reaches the overlap check
// passes S_ROUND, S_TRIM and S_SCAN, the probe walking one cell of the range row a cycle.
// s_tready returns with the result, so the next item is accepted only after that.
// reset (arst_n low) clears the stored count, the failure flag, buffer_length and
// the handshake state; stored ranges are not cleared. a stalled result sits in the
// output register while the next item is accepted.
module load_segment_overlap_checker_core
	import lsoc_pkg::*;
#(
	parameter int unsigned MAX_LOAD_SEGMENTS = 16,
	parameter int unsigned PAGE_BITS         = 12
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// file_offset, file_size, virt_addr, mem_size, alignment
	input  logic [319:0] s_tdata,
	// first_segment, segment_type
	input  logic [32:0]  s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// status, overlap_with, image_ok, ranges_stored, zero pad
	output logic [15:0]  m_tdata,
	input  logic         cfg_we,
	input  logic [63:0]  cfg_wdata
);

	localparam int unsigned CNT_W = $clog2(MAX_LOAD_SEGMENTS + 1);
	localparam logic [DATA_W-1:0] PAGE_MASK = (DATA_W'(1) << PAGE_BITS) - DATA_W'(1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_ROUND,
		S_TRIM,
		S_SCAN,
		S_DONE
	} state_t;

	state_t            state_q;
	logic [DATA_W-1:0] buffer_length_q;
	logic [TYPE_W-1:0] seg_type_q;
	logic [DATA_W-1:0] offset_q;
	logic [DATA_W-1:0] fsize_q;
	logic [DATA_W-1:0] vaddr_q;
	logic [DATA_W-1:0] msize_q;
	logic [DATA_W-1:0] align_q;
	logic [DATA_W-1:0] end_q;
	logic [DATA_W-1:0] mask_q;
	logic [DATA_W-1:0] rnd_q;
	logic [CNT_W-1:0]  count_q;
	logic              failed_q;
	status_t           status_q;
	logic [HIT_W-1:0]  hit_q;
	logic              m_tvalid_q;
	logic [15:0]       m_tdata_q;
	probe_t            head_q;
	logic [DATA_W:0]   sum;
	logic              table_full;
	probe_t            chain [0:MAX_LOAD_SEGMENTS];
	probe_t            tail;

	assign sum        = {1'b0, offset_q} + {1'b0, fsize_q};
	assign table_full = (count_q >= CNT_W'(MAX_LOAD_SEGMENTS));
	assign chain[0]   = head_q;
	assign tail       = chain[MAX_LOAD_SEGMENTS];
	assign s_tready   = (state_q == S_IDLE);
	assign m_tvalid   = m_tvalid_q;
	assign m_tdata    = m_tdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buffer_length_q <= '0;
		end else if (cfg_we) begin
			buffer_length_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			failed_q   <= 1'b0;
			status_q   <= ST_OK;
			hit_q      <= '0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
			head_q     <= '0;
			seg_type_q <= '0;
			offset_q   <= '0;
			fsize_q    <= '0;
			vaddr_q    <= '0;
			msize_q    <= '0;
			align_q    <= '0;
			end_q      <= '0;
			mask_q     <= '0;
			rnd_q      <= '0;
		end else begin
			// the probe enters the row for one cycle
			head_q.valid <= (state_q == S_TRIM);
			if (m_tvalid_q && m_tready && (state_q != S_DONE)) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						seg_type_q <= s_tuser[32:1];
						offset_q   <= s_tdata[63:0];
						fsize_q    <= s_tdata[127:64];
						vaddr_q    <= s_tdata[191:128];
						msize_q    <= s_tdata[255:192];
						align_q    <= s_tdata[319:256];
						if (s_tuser[0]) begin
							count_q  <= '0;
							failed_q <= 1'b0;
						end
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					hit_q <= '0;
					end_q <= vaddr_q + msize_q;
					mask_q <= align_q - DATA_W'(1);
					if (failed_q) begin
						status_q <= ST_SKIPPED;
						state_q  <= S_DONE;
					end else if (sum > {1'b0, buffer_length_q}) begin
						status_q <= ST_BEYOND;
						failed_q <= 1'b1;
						state_q  <= S_DONE;
					end else if (seg_type_q != SEG_TYPE_LOAD) begin
						status_q <= ST_OK;
						state_q  <= S_DONE;
					end else if ((align_q & PAGE_MASK) != '0) begin
						status_q <= ST_MISALIGNED;
						failed_q <= 1'b1;
						state_q  <= S_DONE;
					end else begin
						state_q <= S_ROUND;
					end
				end
				S_ROUND: begin
					rnd_q   <= (end_q + mask_q) & ~mask_q;
					state_q <= S_TRIM;
				end
				S_TRIM: begin
					head_q.range_lo <= vaddr_q;
					head_q.range_hi <= rnd_q - DATA_W'(1);
					head_q.hit      <= 1'b0;
					head_q.hit_idx  <= '0;
					state_q         <= S_SCAN;
				end
				S_SCAN: begin
					if (tail.valid) begin
						if (tail.hit) begin
							status_q <= ST_OVERLAP;
							hit_q    <= tail.hit_idx;
							failed_q <= 1'b1;
						end else if (table_full) begin
							status_q <= ST_FULL;
							failed_q <= 1'b1;
						end else begin
							status_q <= ST_OK;
							count_q  <= count_q + CNT_W'(1);
						end
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {3'b000, CNT_OUT_W'(count_q), !failed_q, hit_q, status_q};
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	for (genvar i = 0; i < MAX_LOAD_SEGMENTS; i++) begin : g_cell
		logic live;
		logic wr_en;

		assign live  = (CNT_W'(i) < count_q);
		assign wr_en = (state_q == S_SCAN) && tail.valid && !tail.hit && !table_full
			&& (count_q == CNT_W'(i));

		lsoc_cell #(
			.INDEX(i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.probe_in (chain[i]),
			.probe_out(chain[i+1]),
			.live     (live),
			.wr_en    (wr_en),
			.wr_lo    (head_q.range_lo),
			.wr_hi    (head_q.range_hi)
		);
	end

endmodule
